@@ rtl/isamp_pkg.sv @@
// Package with payload types, codes and constants for the interval sampler median block.
package isamp_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int MED_W  = 33;
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;

  // Event codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  // Register indexes on the configuration port
  localparam logic REG_SAMPLES_IN_USE = 1'b0;

  localparam logic [CNT_W-1:0] SAMPLES_IN_USE_RST = 7'd64;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic              full_res;
    logic [CNT_W-1:0]  sample_count;
    logic [MED_W-1:0]  median_twice;
  } out_item_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic occ;     // cell holds a stored sample
    logic at_end;  // cell is the first free slot
    logic ins;     // insert the broadcast sample this cycle
  } cell_ctl_t;

endpackage

@@ rtl/isamp_cell.sv @@
// One cell of the sorted insertion chain: holds one sample and shifts right on insert.
module isamp_cell (
  input  logic                        clk,
  input  isamp_pkg::cell_ctl_t        ctl,
  input  logic [isamp_pkg::DATA_W-1:0] new_val,
  input  logic [isamp_pkg::DATA_W-1:0] left_val,
  input  logic                        left_gt,
  output logic [isamp_pkg::DATA_W-1:0] val,
  output logic                        gt
);
  import isamp_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              take;

  // Flag a stored sample above the incoming one
  assign gt = ctl.occ && (val_r > new_val);

  // Take the left neighbor's sample when it moves right, else the new one
  assign take    = ctl.ins && (gt || ctl.at_end);
  assign val_nxt = left_gt ? left_val : new_val;

  always_ff @(posedge clk) begin
    if (take) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

@@ rtl/interval_sampler_median.sv @@
// Top level of the interval sampler median block: control, configuration and cell chain.
// Latency profiler that keeps up to MAX_SAMPLES durations in a row of cells sorted
// ascending. A start event latches the timestamp, a stop event inserts the elapsed
// time (modulo 2^32) into the chain while the count is below the limit, a clear event
// empties the chain and a query returns the sum of the two middle samples (twice the
// median, 0 when empty). In the cycle an item is accepted the two median candidates
// are picked out of the cells and registered; then in S_EXEC, once the output is free,
// the chain shifts to insert a sample or the candidates are added, and the result is
// loaded into the output register. in_stall stays high in S_EXEC, so no new item is
// taken until the last one is done. samples_in_use sits at byte address 0 of the
// configuration port; the limit it sets saturates at MAX_SAMPLES.
module interval_sampler_median #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  isamp_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output isamp_pkg::out_item_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [isamp_pkg::ADDR_W-1:0]  paddr,
  input  logic [isamp_pkg::PDATA_W-1:0] pwdata,
  output logic [isamp_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import isamp_pkg::*;

  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   siu_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [DATA_W-1:0]  start_r;
  logic [1:0]         cmd_mode_r;
  logic [DATA_W-1:0]  cmd_val_r;
  logic [DATA_W-1:0]  lo_sel_r;
  logic [DATA_W-1:0]  hi_sel_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               in_acc;
  logic               out_free;
  logic               exec_go;
  logic               cfg_wr;
  logic [CNT_W-1:0]   limit;
  logic               can_store;
  logic               do_ins;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   lo_idx;
  logic [CMP_W-1:0]   hi_idx;
  logic [DATA_W-1:0]  lo_sel;
  logic [DATA_W-1:0]  hi_sel;
  logic [MED_W-1:0]   med;

  logic [DATA_W-1:0]  cell_val [MAX_SAMPLES];
  logic               cell_gt  [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] match_lo;
  logic [MAX_SAMPLES-1:0] match_hi;

  // Handshakes
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign exec_go  = (state_r == S_EXEC) && out_free;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SAMPLES_IN_USE) ? PDATA_W'(siu_r) : '0;

  // Saturate the limit at the chain length
  assign limit = (CMP_W'(siu_r) > CMP_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : siu_r;
  assign can_store = cnt_r < limit;
  assign do_ins    = exec_go && (cmd_mode_r == MODE_STOP) && can_store;

  // Median candidate positions
  assign cnt_ext = CMP_W'(cnt_r);
  assign lo_idx  = (cnt_ext - CMP_W'(1)) >> 1;
  assign hi_idx  = cnt_ext >> 1;

  // Chain of cells
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    localparam logic [CMP_W-1:0] POS = CMP_W'(i);
    cell_ctl_t          ctl;
    logic [DATA_W-1:0]  left_val;
    logic               left_gt;

    assign ctl.occ    = POS < cnt_ext;
    assign ctl.at_end = POS == cnt_ext;
    assign ctl.ins    = do_ins;
    assign match_lo[i] = POS == lo_idx;
    assign match_hi[i] = POS == hi_idx;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    isamp_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_val  (cmd_val_r),
      .left_val (left_val),
      .left_gt  (left_gt),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  // Pick the two middle samples
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      lo_sel = lo_sel | (cell_val[k] & {DATA_W{match_lo[k]}});
      hi_sel = hi_sel | (cell_val[k] & {DATA_W{match_hi[k]}});
    end
  end

  // Add the candidates; empty store gives zero
  assign med = (cnt_r == '0) ? '0 : ({1'b0, lo_sel_r} + {1'b0, hi_sel_r});

  // Count after the event acts
  always_comb begin
    cnt_nxt = cnt_r;
    case (cmd_mode_r)
      MODE_STOP:  if (can_store) cnt_nxt = cnt_r + CNT_W'(1);
      MODE_CLEAR: cnt_nxt = '0;
      default:    cnt_nxt = cnt_r;
    endcase
  end

  // Latch the transaction and the median candidates
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_mode_r <= in_data.mode;
      cmd_val_r  <= (in_data.mode == MODE_STOP) ? in_data.timestamp - start_r
                                                 : in_data.timestamp;
      lo_sel_r   <= lo_sel;
      hi_sel_r   <= hi_sel;
    end
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      start_r     <= '0;
      siu_r       <= SAMPLES_IN_USE_RST;
    end else begin
      if (cfg_wr && paddr[2] == REG_SAMPLES_IN_USE) begin
        siu_r <= pwdata[CNT_W-1:0];
      end
      if (out_valid_r && !out_stall && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (cmd_mode_r == MODE_START) begin
              start_r <= cmd_val_r;
            end
            cnt_r                   <= cnt_nxt;
            out_valid_r             <= 1'b1;
            out_item_r.full_res     <= cnt_nxt >= limit;
            out_item_r.sample_count <= cnt_nxt;
            out_item_r.median_twice <= (cmd_mode_r == MODE_QUERY) ? med : '0;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Count never passes the chain length
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= CMP_W'(MAX_SAMPLES))
    else $error("sample count beyond chain length");

  // A clear empties the store
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && cmd_mode_r == MODE_CLEAR |=> cnt_r == '0)
    else $error("clear did not empty the store");

  // The chain stays sorted at its head
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (cnt_ext >= CMP_W'(2)) && (MAX_SAMPLES > 1)
      |-> cell_val[0] <= cell_val[(MAX_SAMPLES > 1) ? 1 : 0])
    else $error("sample chain out of order");

  // Only a query yields a nonzero median
  a_med_zero: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && cmd_mode_r != MODE_QUERY |=> out_item_r.median_twice == '0)
    else $error("median reported on a non-query event");

endmodule

@@ bench/isamp_checker.sv @@
`timescale 1ns / 1ps
// Checker for the interval sampler median: tracks the sample store and compares every result.
module isamp_checker #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  isamp_pkg::in_item_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  isamp_pkg::out_item_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [isamp_pkg::ADDR_W-1:0]  paddr,
  input  logic [isamp_pkg::PDATA_W-1:0] pwdata,
  output int                            mismatches,
  output int                            outstanding
);
  import isamp_pkg::*;

  // Shadow state of the profiler
  logic [DATA_W-1:0] t_start;
  logic [DATA_W-1:0] durations [MAX_SAMPLES];
  int unsigned       n_held;
  logic [CNT_W-1:0]  limit_reg;
  out_item_t         expected_q[$];
  int                n_results;

  // Sort the held durations and return twice their median
  function automatic logic [MED_W-1:0] twice_median();
    logic [DATA_W-1:0] srt [MAX_SAMPLES];
    logic [DATA_W-1:0] v;
    int j;
    if (n_held == 0) return '0;
    for (int i = 0; i < n_held; i++) begin
      v = durations[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (n_held[0]) return {1'b0, srt[(n_held-1)/2]} << 1;
    return MED_W'(srt[n_held/2-1]) + MED_W'(srt[n_held/2]);
  endfunction

  // Apply one event to the shadow state and build the result it yields
  function automatic out_item_t apply_event(in_item_t ev);
    out_item_t   r;
    int unsigned lim;
    lim = (limit_reg > MAX_SAMPLES) ? MAX_SAMPLES : limit_reg;
    r = '0;
    case (ev.mode)
      MODE_START: t_start = ev.timestamp;
      MODE_STOP: begin
        // drop the sample once the store is full
        if (n_held < lim) begin
          durations[n_held] = ev.timestamp - t_start;
          n_held++;
        end
      end
      MODE_CLEAR: n_held = 0;
      default: r.median_twice = twice_median();
    endcase
    r.full_res     = (n_held >= lim);
    r.sample_count = CNT_W'(n_held);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    mismatches++;
  endtask

  // Snoop register writes, check results, then queue predictions
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      t_start     = '0;
      n_held      = 0;
      limit_reg   = SAMPLES_IN_USE_RST;
      n_results   = 0;
      mismatches  = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) == REG_SAMPLES_IN_USE)
        limit_reg = pwdata[CNT_W-1:0];
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", n_results));
        end else begin
          want = expected_q.pop_front();
          if (out_data.full_res !== want.full_res)
            report_mismatch($sformatf("result %0d full_res got %0b expected %0b",
                                      n_results, out_data.full_res, want.full_res));
          if (out_data.sample_count !== want.sample_count)
            report_mismatch($sformatf("result %0d sample_count got %0d expected %0d",
                                      n_results, out_data.sample_count, want.sample_count));
          if (out_data.median_twice !== want.median_twice)
            report_mismatch($sformatf("result %0d median_twice got %0h expected %0h",
                                      n_results, out_data.median_twice, want.median_twice));
        end
        n_results++;
      end
      if (in_valid && !in_stall)
        expected_q.push_back(apply_event(in_data));
    end
    outstanding = expected_q.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the interval sampler median: clock, reset, stimulus and verdict.
module tb;
  import isamp_pkg::*;

  localparam int MAX_SAMPLES   = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int UNMAPPED_REG  = 1;
  localparam int SETTLE_CYCLES = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;
  int                 cycles = 0;
  bit                 quiet = 1'b0;

  interval_sampler_median #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  isamp_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("interval_sampler_median verification failed");
      $finish;
    end
  end

  // Idle cycles per transaction; quiet phases run back to back
  function automatic int draw_wait();
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  // Stall the result channel for a random stretch after each transaction
  initial begin : result_sink
    int  stall_left;
    bit  taken;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      taken = out_valid && !out_stall;
      @(negedge clk);
      if (taken) stall_left = draw_wait();
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Present one event after a random gap and hold it until accepted
  task automatic send_item(input mode_t m, input logic [DATA_W-1:0] ts);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data.mode      = m;
    in_data.timestamp = ts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Drain, then write one register through a setup and an access cycle
  task automatic reconfigure(input int idx, input logic [CNT_W-1:0] value);
    wait_for_results();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_W'(idx << 2);
    pwdata  = PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Mostly start/stop pairs with random durations, plus queries, clears and noise
  task automatic run_traffic(input int n_items, input int clear_pct);
    int               sent;
    int               pick;
    logic [DATA_W-1:0] t0;
    logic [DATA_W-1:0] dur;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(mode_t'($urandom_range(0, 3)), $urandom);
        sent++;
      end else if (pick < 5 + clear_pct) begin
        send_item(MODE_CLEAR, $urandom);
        sent++;
      end else if (pick < 22 + clear_pct) begin
        send_item(MODE_QUERY, $urandom);
        sent++;
      end else begin
        t0 = $urandom;
        case ($urandom_range(0, 4))
          0: dur = $urandom_range(0, 3);
          1: dur = $urandom_range(0, 1000);
          2: dur = $urandom;
          3: dur = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: dur = $urandom_range(0, 100) * 1000;
        endcase
        send_item(MODE_START, t0);
        send_item(MODE_STOP, t0 + dur);
        sent += 2;
      end
    end
  endtask

  initial begin : stimulus
    int lim;
    int clr;
    int n;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty store, wrapped and extreme durations, odd and even counts
    send_item(MODE_QUERY, 32'hFFFF_FFFF);
    send_item(MODE_STOP, 32'h0);
    send_item(MODE_START, 32'hFFFF_FFFF);
    send_item(MODE_STOP, 32'h0);
    send_item(MODE_START, 32'h0);
    send_item(MODE_STOP, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, 32'h0);
    send_item(MODE_START, 32'd12345);
    send_item(MODE_STOP, 32'd12352);
    send_item(MODE_QUERY, 32'h5555_5555);
    send_item(MODE_START, 32'd1);
    send_item(MODE_STOP, 32'd0);
    send_item(MODE_START, 32'd2);
    send_item(MODE_STOP, 32'd1);
    send_item(MODE_STOP, 32'd1);
    send_item(MODE_QUERY, 32'hAAAA_AAAA);
    send_item(MODE_CLEAR, 32'h0);
    send_item(MODE_QUERY, 32'h0);

    // Zero limit: always full, every stop dropped
    reconfigure(REG_SAMPLES_IN_USE, 7'd0);
    send_item(MODE_STOP, 32'd99);
    send_item(MODE_QUERY, 32'h0);

    // Small limit, then stops while full
    reconfigure(REG_SAMPLES_IN_USE, 7'd2);
    send_item(MODE_START, 32'd10);
    send_item(MODE_STOP, 32'd20);
    send_item(MODE_STOP, 32'd30);
    send_item(MODE_STOP, 32'd40);
    send_item(MODE_QUERY, 32'h0);

    // Limit lowered below the count keeps the samples; unmapped write has no effect
    reconfigure(REG_SAMPLES_IN_USE, 7'd1);
    send_item(MODE_QUERY, 32'h0);
    reconfigure(UNMAPPED_REG, 7'd100);
    send_item(MODE_STOP, 32'd50);
    reconfigure(REG_SAMPLES_IN_USE, 7'd127);
    send_item(MODE_STOP, 32'd60);
    send_item(MODE_QUERY, 32'h0);

    // Random phases over a range of limits
    for (int p = 0; p < 7; p++) begin
      quiet = 1'b0;
      case (p)
        0: begin lim = 64; clr = 0; n = 200; end
        1: begin lim = 3; clr = 2; n = 80; end
        2: begin lim = 0; clr = 2; n = 60; end
        3: begin lim = 127; clr = 1; n = 120; quiet = 1'b1; end
        4: begin lim = $urandom_range(1, 63); clr = 3; n = 100; end
        5: begin lim = $urandom_range(65, 126); clr = 1; n = 80; quiet = 1'b1; end
        default: begin lim = 1; clr = 5; n = 60; end
      endcase
      reconfigure(REG_SAMPLES_IN_USE, CNT_W'(lim));
      run_traffic(n, clr);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("interval_sampler_median verification clean");
    else
      $display("interval_sampler_median verification failed");
    $finish;
  end

endmodule
